/* rtl/core/dcpl_pkg.sv */
// Shared widths, register indexes and constants for the diagonal contrast peak locator.
package dcpl_pkg;

	localparam int PIXEL_W    = 16;
	localparam int COORD_W    = 13;
	localparam int SCORE_W    = 17;
	localparam int ORIGIN_W   = 12;
	localparam int ROW_W      = 12;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_ADDR_W = 2;
	localparam int MAX_HEIGHT = 4096;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_ORIGIN_COL   = 2'd2,
		REG_ORIGIN_ROW   = 2'd3
	} cfg_reg_t;

endpackage

/* rtl/core/dcpl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dcpl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/diagonal_contrast_peak_locator.sv */
// Top level: raster pixel stream in, one peak location and score out per region.
//
// Pixels arrive on in_valid/in_ready in raster order, one word per cycle
// sustained. Each interior pixel is scored as the sum of the absolute
// differences across its two diagonals; the largest score above zero and its
// absolute column and row are tracked, the first in raster order winning ties.
// Two previous rows sit in one line RAM (both rows side by side in one word),
// read at the column of the incoming pixel and written back in the next cycle.
// When the region's last pixel is taken, it passes stage 1 and stage 2 into
// the output register behind out_valid, and tracking clears at that capture.
// Throughput is one pixel per cycle, set by the single line RAM read and write
// per pixel. A result waits in the output register until out_ready; only
// the last pixel of the next region is held off while it waits, all other
// pixels keep flowing. Registers are written on cfg_we; the user must write
// them only while idle; the block does not enforce this. A size write restarts
// the region. Reset clears counters, delays and the peak; the line RAM needs
// no clearing since every row read was written earlier in the same region.
module diagonal_contrast_peak_locator #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [dcpl_pkg::PIXEL_W-1:0]     pixel,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [dcpl_pkg::COORD_W-1:0]     best_col,
	output logic [dcpl_pkg::COORD_W-1:0]     best_row,
	output logic [dcpl_pkg::SCORE_W-1:0]     best_score,
	input  logic                             cfg_we,
	input  logic [dcpl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [dcpl_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import dcpl_pkg::*;

	localparam int PW = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int SW = PW + 1;
	localparam logic [AW-1:0] COL_LAST_MAX = AW'(MAX_WIDTH - 1);
	localparam logic [AW-1:0] COL_LAST_RST = AW'(((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024) - 1);
	localparam logic [ROW_W-1:0] ROW_LAST_MAX = ROW_W'(MAX_HEIGHT - 1);
	localparam logic [ROW_W-1:0] ROW_LAST_RST = ROW_W'(1023);

	// configuration
	logic [AW-1:0]       col_last_q;
	logic [ROW_W-1:0]    row_last_q;
	logic [ORIGIN_W-1:0] origin_col_q;
	logic [ORIGIN_W-1:0] origin_row_q;
	logic                restart;
	logic [AW-1:0]       col_last_d;
	logic [ROW_W-1:0]    row_last_d;
	logic [10:0]         w_in;
	logic [12:0]         h_in;

	assign w_in = cfg_data[10:0];
	assign h_in = cfg_data[12:0];

	always_comb begin
		if (w_in < 11'd3) begin
			col_last_d = AW'(2);
		end else if (32'(w_in) > MAX_WIDTH) begin
			col_last_d = COL_LAST_MAX;
		end else begin
			col_last_d = AW'(w_in - 11'd1);
		end
		if (h_in < 13'd3) begin
			row_last_d = ROW_W'(2);
		end else if (32'(h_in) > MAX_HEIGHT) begin
			row_last_d = ROW_LAST_MAX;
		end else begin
			row_last_d = ROW_W'(h_in - 13'd1);
		end
	end

	always_comb begin
		restart = 1'b0;
		if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_FRAME_WIDTH:  restart = 1'b1;
				REG_FRAME_HEIGHT: restart = 1'b1;
				REG_ORIGIN_COL:   restart = 1'b0;
				REG_ORIGIN_ROW:   restart = 1'b0;
				default:          restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q   <= COL_LAST_RST;
			row_last_q   <= ROW_LAST_RST;
			origin_col_q <= '0;
			origin_row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_FRAME_WIDTH:  col_last_q   <= col_last_d;
				REG_FRAME_HEIGHT: row_last_q   <= row_last_d;
				REG_ORIGIN_COL:   origin_col_q <= cfg_data[ORIGIN_W-1:0];
				REG_ORIGIN_ROW:   origin_row_q <= cfg_data[ORIGIN_W-1:0];
				default:          origin_row_q <= origin_row_q;
			endcase
		end
	end

	// stage 0: position counters, line RAM read
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             at_last_col;
	logic             at_last;
	logic             accept;
	logic             out_valid_q;
	logic             v_s1, v_s2;
	logic             last_s1, last_s2;

	assign at_last_col = (col_q == col_last_q);
	assign at_last     = at_last_col && (row_q == row_last_q);

	// only the region's last word is held back while a result is still pending
	assign in_ready = !(at_last && ((v_s1 && last_s1) || (v_s2 && last_s2) ||
		(out_valid_q && !out_ready)));
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (at_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (at_last_col) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// stage 1: line data back, score the pixel, write rows back
	logic [PW-1:0]    pix_s1;
	logic [AW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             int_s1;
	logic [2*PW-1:0]  line_rdata;
	logic [PW-1:0]    above;
	logic [PW-1:0]    two_above;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel[PW-1:0];
			col_s1  <= col_q;
			row_s1  <= row_q;
			int_s1  <= (row_q >= ROW_W'(2)) && (col_q >= AW'(2));
			last_s1 <= at_last;
		end
	end

	dcpl_ram #(
		.WIDTH(2 * PW),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (v_s1),
		.waddr(col_s1),
		.wdata({pix_s1, above}),
		.re   (accept),
		.raddr(col_q),
		.rdata(line_rdata)
	);

	assign above     = line_rdata[2*PW-1:PW];
	assign two_above = line_rdata[PW-1:0];

	logic [PW-1:0] cur0_q, cur1_q, old0_q, old1_q;
	logic [PW-1:0] diff_a, diff_b;
	logic [SW-1:0] score;

	always_comb begin
		diff_a = (old1_q > pix_s1) ? (old1_q - pix_s1) : (pix_s1 - old1_q);
		diff_b = (two_above > cur1_q) ? (two_above - cur1_q) : (cur1_q - two_above);
		score  = SW'(diff_a) + SW'(diff_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur0_q <= '0;
			cur1_q <= '0;
			old0_q <= '0;
			old1_q <= '0;
		end else if (v_s1) begin
			cur1_q <= cur0_q;
			cur0_q <= pix_s1;
			old1_q <= old0_q;
			old0_q <= two_above;
		end
	end

	// stage 2: compare against the tracked peak, emit at region end
	logic [SW-1:0]      score_s2;
	logic [AW-1:0]      col_s2;
	logic [ROW_W-1:0]   row_s2;
	logic [SW-1:0]      peak_score_q;
	logic [COORD_W-1:0] peak_col_q;
	logic [COORD_W-1:0] peak_row_q;
	logic               better;
	logic [13:0]        abs_col;
	logic [13:0]        abs_row;
	logic [SW-1:0]      next_score;
	logic [COORD_W-1:0] next_col;
	logic [COORD_W-1:0] next_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			score_s2 <= int_s1 ? score : '0;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			last_s2  <= last_s1;
		end
	end

	always_comb begin
		better  = score_s2 > peak_score_q;
		abs_col = 14'(origin_col_q) + 14'(col_s2) - 14'd1;
		abs_row = 14'(origin_row_q) + 14'(row_s2) - 14'd1;
		next_score = better ? score_s2 : peak_score_q;
		next_col   = better ? abs_col[COORD_W-1:0] : peak_col_q;
		next_row   = better ? abs_row[COORD_W-1:0] : peak_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_score_q <= '0;
			peak_col_q   <= '0;
			peak_row_q   <= '0;
		end else if (restart || (v_s2 && last_s2)) begin
			peak_score_q <= '0;
			peak_col_q   <= '0;
			peak_row_q   <= '0;
		end else if (v_s2) begin
			peak_score_q <= next_score;
			peak_col_q   <= next_col;
			peak_row_q   <= next_row;
		end
	end

	logic [COORD_W-1:0] best_col_q;
	logic [COORD_W-1:0] best_row_q;
	logic [SW-1:0]      best_score_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s2 && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && last_s2) begin
			best_col_q   <= next_col;
			best_row_q   <= next_row;
			best_score_q <= next_score;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_col   = best_col_q;
	assign best_row   = best_row_q;
	assign best_score = SCORE_W'(best_score_q);

`ifndef SYNTHESIS
	// a finished region never lands on a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && last_s2) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	a_one_last_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1 && last_s1, v_s2 && last_s2}))
		else $error("two region ends in flight");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && last_s2) |=> out_valid_q)
		else $error("region end produced no result");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ((col_q <= col_last_q) && (row_q <= row_last_q)))
		else $error("position counter beyond region");

	a_zero_peak_loc: assert property (@(posedge clk) disable iff (!arst_n)
		(peak_score_q == '0) |-> ((peak_col_q == '0) && (peak_row_q == '0)))
		else $error("peak location set without a score");
`endif

endmodule

/* tb/tb_diagonal_contrast_peak_locator.sv */
// Self-checking testbench for the diagonal contrast peak locator: random regions, scored peaks.
module tb_diagonal_contrast_peak_locator;
	import dcpl_pkg::*;

	localparam int          LINE_DEPTH   = 1024;
	localparam int unsigned MODE_ITEMS   = 250;
	localparam int unsigned SETTLE       = 16;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [SCORE_W-1:0] score;
	} peak_report_t;

	typedef enum int {PIX_RANDOM, PIX_LOW, PIX_RAIL, PIX_FLAT} pix_style_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [PIXEL_W-1:0]    pixel     = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [COORD_W-1:0]    best_col;
	logic [COORD_W-1:0]    best_row;
	logic [SCORE_W-1:0]    best_score;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	diagonal_contrast_peak_locator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.best_col   (best_col),
		.best_row   (best_row),
		.best_score (best_score),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data)
	);

	logic [PIXEL_W-1:0] pixel_queue [$];
	peak_report_t       peak_expect [$];
	int unsigned        fail_count    = 0;
	int unsigned        cycle_count   = 0;
	int unsigned        send_idle_pct = 0;
	int unsigned        recv_idle_pct = 0;
	int unsigned        hold_req      = 0;
	int unsigned        hold_ack      = 0;
	int unsigned        hold_left     = 0;

	// predictor state and its copy of the registers
	logic [10:0]          reg_width  = 11'd1024;
	logic [12:0]          reg_height = 13'd1024;
	logic [ORIGIN_W-1:0]  reg_org_col = '0;
	logic [ORIGIN_W-1:0]  reg_org_row = '0;
	logic [PIXEL_W-1:0]   row_m1 [LINE_DEPTH];
	logic [PIXEL_W-1:0]   row_m2 [LINE_DEPTH];
	logic [PIXEL_W-1:0]   cur_tap [2];
	logic [PIXEL_W-1:0]   old_tap [2];
	int unsigned          col_pos = 0;
	int unsigned          row_pos = 0;
	logic [SCORE_W-1:0]   trk_score = '0;
	logic [COORD_W-1:0]   trk_col = '0;
	logic [COORD_W-1:0]   trk_row = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		foreach (row_m1[i]) begin
			row_m1[i] = '0;
			row_m2[i] = '0;
		end
		cur_tap = '{default: '0};
		old_tap = '{default: '0};
	end

	function automatic int unsigned eff_width();
		if (reg_width < 3) return 3;
		if (reg_width > LINE_DEPTH) return LINE_DEPTH;
		return 32'(reg_width);
	endfunction

	function automatic int unsigned eff_height();
		if (reg_height < 3) return 3;
		if (reg_height > MAX_HEIGHT) return MAX_HEIGHT;
		return 32'(reg_height);
	endfunction

	function automatic logic [SCORE_W-1:0] abs_diff(input logic [PIXEL_W-1:0] a,
			input logic [PIXEL_W-1:0] b);
		return (a > b) ? SCORE_W'(a - b) : SCORE_W'(b - a);
	endfunction

	task automatic restart_tracking();
		col_pos = 0;
		row_pos = 0;
		trk_score = '0;
		trk_col = '0;
		trk_row = '0;
	endtask

	// one accepted pixel through the scoring window
	task automatic track_pixel(input logic [PIXEL_W-1:0] p);
		int unsigned w, h, c, r;
		logic [PIXEL_W-1:0] up1, up2;
		logic [SCORE_W-1:0] score;
		peak_report_t rep;
		w = eff_width();
		h = eff_height();
		c = col_pos;
		r = row_pos;
		if (c >= w) c = w - 1;
		if (r >= h) r = h - 1;
		up1 = row_m1[c];
		up2 = row_m2[c];
		if (r >= 2 && c >= 2) begin
			score = abs_diff(old_tap[1], p) + abs_diff(up2, cur_tap[1]);
			if (score > trk_score) begin
				trk_score = score;
				trk_col = COORD_W'(reg_org_col + c - 1);
				trk_row = COORD_W'(reg_org_row + r - 1);
			end
		end
		row_m2[c] = up1;
		row_m1[c] = p;
		old_tap[1] = old_tap[0];
		old_tap[0] = up2;
		cur_tap[1] = cur_tap[0];
		cur_tap[0] = p;
		if (c == w - 1 && r == h - 1) begin
			rep.col = trk_col;
			rep.row = trk_row;
			rep.score = trk_score;
			peak_expect.push_back(rep);
			restart_tracking();
		end else if (c == w - 1) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// driver: next word only after the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				track_pixel(pixel);
			if (!in_valid || in_ready) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					pixel <= pixel_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// monitor and receiver; a hold-off request stalls out_ready for a long stretch
	always @(posedge clk or negedge arst_n) begin
		peak_report_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (peak_expect.size() == 0) begin
					$display("%0t: unexpected word: col %0d row %0d score %0d",
						$time, best_col, best_row, best_score);
					fail_count++;
				end else begin
					want = peak_expect.pop_front();
					check_field("best_col", 32'(want.col), 32'(best_col));
					check_field("best_row", 32'(want.row), 32'(best_row));
					check_field("best_score", 32'(want.score), 32'(best_score));
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words still expected", $time, peak_expect.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: begin
				reg_width = val[10:0];
				restart_tracking();
			end
			REG_FRAME_HEIGHT: begin
				reg_height = val[12:0];
				restart_tracking();
			end
			REG_ORIGIN_COL: reg_org_col = val[ORIGIN_W-1:0];
			REG_ORIGIN_ROW: reg_org_row = val[ORIGIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pixel_queue.size() != 0 || in_valid || peak_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_all(input logic [12:0] w, input logic [12:0] h,
			input logic [12:0] oc, input logic [12:0] orow);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_ORIGIN_COL, oc);
		write_reg(REG_ORIGIN_ROW, orow);
		@(negedge clk);
	endtask

	function automatic logic [PIXEL_W-1:0] pick_pixel(input pix_style_t style,
			input logic [PIXEL_W-1:0] flat);
		case (style)
			PIX_RANDOM: return PIXEL_W'($urandom);
			PIX_LOW:    return PIXEL_W'($urandom_range(3));
			PIX_RAIL:   return $urandom_range(1) ? {PIXEL_W{1'b1}} : '0;
			default:    return flat;
		endcase
	endfunction

	task automatic queue_region(input int unsigned count);
		pix_style_t style;
		logic [PIXEL_W-1:0] flat;
		int unsigned roll;
		roll = $urandom_range(99);
		flat = PIXEL_W'($urandom);
		if (roll < 50) style = PIX_RANDOM;
		else if (roll < 75) style = PIX_LOW;
		else if (roll < 90) style = PIX_RAIL;
		else style = PIX_FLAT;
		repeat (count) pixel_queue.push_back(pick_pixel(style, flat));
	endtask

	function automatic logic [12:0] pick_origin();
		case ($urandom_range(3))
			0: return 13'h0000;
			1: return 13'h1fff;
			2: return 13'h0fff;
			default: return 13'($urandom);
		endcase
	endfunction

	initial begin
		logic [PIXEL_W-1:0] peak_pat [9];
		logic [12:0] w_raw, h_raw;
		int unsigned mode, mode_items, n_regions, area, cut;
		bit hold_done;
		peak_pat = '{16'h0000, 16'h0000, 16'hffff, 16'h1234, 16'h5678, 16'h9abc,
			16'h0000, 16'hffff, 16'hffff};
		hold_done = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: full-scale score at the largest origins, then a flat region
		send_idle_pct = 9;
		recv_idle_pct = 51;
		write_all(13'd3, 13'd3, 13'h0fff, 13'h0fff);
		foreach (peak_pat[i]) pixel_queue.push_back(peak_pat[i]);
		repeat (9) pixel_queue.push_back(16'h8000);
		wait_drained();

		// size write in the middle of a region restarts it; upper data bits dropped
		queue_region(2);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'h1803);
		write_reg(REG_FRAME_HEIGHT, 13'd4);
		write_reg(REG_ORIGIN_COL, 13'd0);
		write_reg(REG_ORIGIN_ROW, 13'd0);
		@(negedge clk);

		// origin change between the two interior rows
		repeat (9) pixel_queue.push_back(PIXEL_W'($urandom));
		wait_drained();
		write_reg(REG_ORIGIN_COL, 13'd100);
		write_reg(REG_ORIGIN_ROW, 13'd2000);
		@(negedge clk);
		repeat (3) pixel_queue.push_back(PIXEL_W'($urandom));
		wait_drained();

		for (mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 51 : 0;
			recv_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 9 : 0;
			mode_items = 0;
			while (mode_items < MODE_ITEMS) begin
				if ($urandom_range(99) < 85) w_raw = 13'($urandom_range(3, 8));
				else if ($urandom_range(1)) w_raw = 13'($urandom_range(0, 2));
				else w_raw = 13'h1800 | 13'($urandom_range(3, 8));
				if ($urandom_range(99) < 85) h_raw = 13'($urandom_range(3, 6));
				else h_raw = 13'($urandom_range(0, 2));
				write_all(w_raw, h_raw, pick_origin(), pick_origin());
				area = eff_width() * eff_height();
				n_regions = $urandom_range(1, 4);
				if (!hold_done) begin
					// long receiver stall while several regions are offered
					n_regions = 4;
					hold_req++;
					hold_done = 1'b1;
				end
				repeat (n_regions - 1) queue_region(area);
				if ($urandom_range(99) < 10) begin
					cut = $urandom_range(1, area - 1);
					queue_region(cut);
				end else begin
					queue_region(area);
				end
				mode_items += area * n_regions;
				wait_drained();
			end
		end

		// a wide region and a tall one
		write_all(13'd200, 13'd3, pick_origin(), pick_origin());
		queue_region(eff_width() * eff_height());
		wait_drained();
		write_all(13'd3, 13'd150, 13'h0fff, 13'h0fff);
		queue_region(eff_width() * eff_height());
		wait_drained();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
